>>> rtl/core/rme_pkg.sv
// Shared constants, register indexes and state type for the modular exponentiation block.
package rme_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 16;
   localparam int PLAIN_WIDTH         = 8;
   localparam int CSR_INDEX_WIDTH     = 1;

   localparam int unsigned RESET_EXPONENT = 23;
   localparam int unsigned RESET_MODULUS  = 143;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPONENT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_DECIDE,
      S_MULT,
      S_SQCHK,
      S_SQUARE
   } state_type;

endpackage

>>> rtl/core/rsa_modexp_decrypt.sv
// Top level: RSA decryption of one value by square-and-multiply over a bit-serial multiplier.
// Throughput: one request at a time; busy stays high from accept until the result strobe,
// except when the modulus is below 2, in which case busy never rises.
// Modulus below 2 gives result 0 in the cycle after accept. The receiver cannot stall.
// Synchronous reset returns control to idle and loads exponent 23 and modulus 143.
module rsa_modexp_decrypt #(
   parameter int VALUE_WIDTH = rme_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [VALUE_WIDTH-1:0]                req_cipher_value,
   output logic                                  rsp_valid,
   output logic [rme_pkg::PLAIN_WIDTH-1:0]       rsp_plain_byte,
   input  logic                                  csr_we,
   input  logic [rme_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [VALUE_WIDTH-1:0]                csr_wdata
);
   import rme_pkg::*;

   state_type state_ff;
   state_type state_in;

   logic [VALUE_WIDTH-1:0] exp_cfg_ff;
   logic [VALUE_WIDTH-1:0] mod_cfg_ff;

   logic [VALUE_WIDTH-1:0] cipher_ff, cipher_in;
   logic [VALUE_WIDTH-1:0] exp_ff, exp_in;
   logic [VALUE_WIDTH-1:0] n_ff, n_in;
   logic [VALUE_WIDTH-1:0] base_ff, base_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   start_ff, start_in;
   logic                   valid_ff, valid_in;
   logic [PLAIN_WIDTH-1:0] plain_ff, plain_in;

   logic                   accept;
   logic [VALUE_WIDTH-1:0] mul_a;
   logic [VALUE_WIDTH-1:0] mul_b;
   logic                   mul_busy;
   logic                   mul_done;
   logic [VALUE_WIDTH-1:0] mul_product;

   assign accept = start && (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_cfg_ff <= VALUE_WIDTH'(RESET_EXPONENT);
         mod_cfg_ff <= VALUE_WIDTH'(RESET_MODULUS);
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXPONENT: exp_cfg_ff <= csr_wdata;
            CSR_MODULUS:  mod_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (state_ff)
         S_REDUCE: begin
            mul_a = cipher_ff;
            mul_b = VALUE_WIDTH'(1);
         end
         S_MULT: begin
            mul_a = acc_ff;
            mul_b = base_ff;
         end
         default: begin
            mul_a = base_ff;
            mul_b = base_ff;
         end
      endcase
   end

   rme_modmul #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_modmul (
      .clock       (clock),
      .reset       (reset),
      .mul_start   (start_ff),
      .op_a        (mul_a),
      .op_b        (mul_b),
      .op_modulus  (n_ff),
      .mul_busy    (mul_busy),
      .mul_done    (mul_done),
      .mul_product (mul_product)
   );

   always_comb begin
      state_in  = state_ff;
      cipher_in = cipher_ff;
      exp_in    = exp_ff;
      n_in      = n_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      start_in  = 1'b0;
      valid_in  = 1'b0;
      plain_in  = plain_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cipher_in = req_cipher_value;
               exp_in    = (exp_cfg_ff == '0) ? VALUE_WIDTH'(1) : exp_cfg_ff;
               n_in      = mod_cfg_ff;
               if (mod_cfg_ff < VALUE_WIDTH'(2)) begin
                  valid_in = 1'b1;
                  plain_in = '0;
               end else begin
                  start_in = 1'b1;
                  state_in = S_REDUCE;
               end
            end
         end
         S_REDUCE: begin
            if (mul_done) begin
               base_in  = mul_product;
               acc_in   = VALUE_WIDTH'(1);
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (exp_ff[0]) begin
               start_in = 1'b1;
               state_in = S_MULT;
            end else begin
               state_in = S_SQCHK;
            end
         end
         S_MULT: begin
            if (mul_done) begin
               acc_in   = mul_product;
               state_in = S_SQCHK;
            end
         end
         S_SQCHK: begin
            if (exp_ff[VALUE_WIDTH-1:1] == '0) begin
               valid_in = 1'b1;
               plain_in = acc_ff[PLAIN_WIDTH-1:0];
               state_in = S_IDLE;
            end else begin
               start_in = 1'b1;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            if (mul_done) begin
               base_in  = mul_product;
               exp_in   = {1'b0, exp_ff[VALUE_WIDTH-1:1]};
               state_in = S_DECIDE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         start_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cipher_ff <= cipher_in;
      exp_ff    <= exp_in;
      n_ff      <= n_in;
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      plain_ff  <= plain_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_plain_byte = plain_ff;

   a_start_in_mul_state: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (state_ff == S_REDUCE || state_ff == S_MULT || state_ff == S_SQUARE))
      else $error("multiplier launched outside a multiply state");

   a_done_in_mul_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_REDUCE || state_ff == S_MULT || state_ff == S_SQUARE))
      else $error("multiplier finished outside a multiply state");

   a_idle_mul_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!mul_busy && !start_ff))
      else $error("multiplier active while idle");

   a_accept_to_reduce: assert property (@(posedge clock) disable iff (reset)
      (accept && (mod_cfg_ff >= VALUE_WIDTH'(2))) |=> (state_ff == S_REDUCE))
      else $error("accepted request did not start reduction");

   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |-> ((acc_ff < n_ff) && (base_ff < n_ff)))
      else $error("accumulator or base not below modulus");

endmodule

>>> rtl/core/rme_modmul.sv
// Bit-serial interleaved modular multiplier: one bit of op_a per cycle, MSB first.
module rme_modmul #(
   parameter int VALUE_WIDTH = rme_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   mul_start,
   input  logic [VALUE_WIDTH-1:0] op_a,
   input  logic [VALUE_WIDTH-1:0] op_b,
   input  logic [VALUE_WIDTH-1:0] op_modulus,
   output logic                   mul_busy,
   output logic                   mul_done,
   output logic [VALUE_WIDTH-1:0] mul_product
);
   import rme_pkg::*;

   localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
   localparam int SUM_W = VALUE_WIDTH + 2;

   logic                   busy_ff;
   logic                   done_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [VALUE_WIDTH-1:0] a_ff;
   logic [VALUE_WIDTH-1:0] b_ff;
   logic [VALUE_WIDTH-1:0] n_ff;
   logic [VALUE_WIDTH-1:0] r_ff;
   logic [VALUE_WIDTH-1:0] r_in;

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] n_one;
   logic [SUM_W-1:0] n_two;
   logic [SUM_W-1:0] sum_sub1;
   logic [SUM_W-1:0] sum_sub2;

   always_comb begin
      n_one    = {2'b00, n_ff};
      n_two    = {1'b0, n_ff, 1'b0};
      sum      = {1'b0, r_ff, 1'b0} + (a_ff[VALUE_WIDTH-1] ? {2'b00, b_ff} : '0);
      sum_sub1 = sum - n_one;
      sum_sub2 = sum - n_two;
      if (sum >= n_two) begin
         r_in = sum_sub2[VALUE_WIDTH-1:0];
      end else if (sum >= n_one) begin
         r_in = sum_sub1[VALUE_WIDTH-1:0];
      end else begin
         r_in = sum[VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mul_start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(VALUE_WIDTH - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_start) begin
         a_ff <= op_a;
         b_ff <= op_b;
         n_ff <= op_modulus;
         r_ff <= '0;
      end else if (busy_ff) begin
         a_ff <= {a_ff[VALUE_WIDTH-2:0], 1'b0};
         r_ff <= r_in;
      end
   end

   assign mul_busy    = busy_ff;
   assign mul_done    = done_ff;
   assign mul_product = r_ff;

   a_rem_below_mod: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (b_ff < n_ff)) |-> (r_ff < n_ff))
      else $error("partial remainder not reduced below modulus");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for rsa_modexp_decrypt: directed and random requests against a predictor.
module testbench;
   import rme_pkg::*;

   localparam int VW           = VALUE_WIDTH_DEFAULT;
   localparam int STALL_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 700;
   localparam int PRINT_LIMIT  = 50;
   localparam int RANDOM_PHASES = 17;
   localparam int PHASE_REQUESTS = 100;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [VW-1:0]                req_cipher_value = '0;
   logic                         rsp_valid;
   logic [PLAIN_WIDTH-1:0]       rsp_plain_byte;
   logic                         csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index = CSR_EXPONENT;
   logic [VW-1:0]                csr_wdata = '0;

   logic [VW-1:0]                exponent_setting = VW'(RESET_EXPONENT);
   logic [VW-1:0]                modulus_setting  = VW'(RESET_MODULUS);
   logic [PLAIN_WIDTH-1:0]       expected_plain[$];
   int unsigned                  error_count = 0;
   int unsigned                  stall_cycles = 0;
   int unsigned                  gapless_left = 0;

   rsa_modexp_decrypt #(.VALUE_WIDTH(VW)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cipher_value (req_cipher_value),
      .rsp_valid        (rsp_valid),
      .rsp_plain_byte   (rsp_plain_byte),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [PLAIN_WIDTH-1:0] decrypt_byte(input logic [VW-1:0] cipher);
      logic [31:0] acc;
      logic [31:0] base;
      logic [31:0] n;
      logic [VW-1:0] power;
      if (modulus_setting < 2)
         return '0;
      n = 32'(modulus_setting);
      power = (exponent_setting == 0) ? VW'(1) : exponent_setting;
      base = 32'(cipher) % n;
      acc = 1;
      while (power != 0) begin
         if (power[0])
            acc = (acc * base) % n;
         base = (base * base) % n;
         power = power >> 1;
      end
      return acc[PLAIN_WIDTH-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("mismatch: %s", msg);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      logic [PLAIN_WIDTH-1:0] want;
      if (!reset && rsp_valid) begin
         if (expected_plain.size() == 0) begin
            report_mismatch($sformatf("plain_byte %0h with no request outstanding",
                                      rsp_plain_byte));
         end else begin
            want = expected_plain.pop_front();
            if (rsp_plain_byte !== want)
               report_mismatch($sformatf("plain_byte %0h, expected %0h", rsp_plain_byte, want));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send_cipher(input logic [VW-1:0] cipher);
      int unsigned gap;
      if (gapless_left != 0) begin
         gapless_left--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 19);
      end
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cipher_value <= cipher;
      do @(posedge clock); while (busy);
      expected_plain.push_back(decrypt_byte(cipher));
   endtask

   // hold off until every outstanding request has returned
   task automatic wait_drained();
      start <= 1'b0;
      while (expected_plain.size() != 0 || busy)
         @(posedge clock);
   endtask

   task automatic apply_settings(input logic [VW-1:0] exponent, input logic [VW-1:0] modulus);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= CSR_EXPONENT;
      csr_wdata <= exponent;
      @(posedge clock);
      csr_index <= CSR_MODULUS;
      csr_wdata <= modulus;
      @(posedge clock);
      csr_we <= 1'b0;
      exponent_setting = exponent;
      modulus_setting = modulus;
   endtask

   task automatic test_reset_settings();
      send_cipher(16'd0);
      send_cipher(16'd1);
      send_cipher(16'd142);
      send_cipher(16'd143);
      send_cipher(16'd144);
      send_cipher(16'hFFFF);
   endtask

   task automatic test_special_cases();
      // exponent zero acts as one
      apply_settings(16'd0, 16'd143);
      send_cipher(16'd200);
      send_cipher(16'd77);
      // modulus one and zero force a zero result
      apply_settings(16'd23, 16'd1);
      send_cipher(16'hFFFF);
      send_cipher(16'd5);
      apply_settings(16'd23, 16'd0);
      send_cipher(16'hFFFF);
      send_cipher(16'd5);
      // exponent one must still reduce the input
      apply_settings(16'd1, 16'd251);
      send_cipher(16'hFFFF);
      send_cipher(16'd300);
   endtask

   task automatic test_extreme_settings();
      apply_settings(16'hFFFF, 16'hFFFF);
      send_cipher(16'hAAAA);
      send_cipher(16'h5555);
      send_cipher(16'hFFFE);
      apply_settings(16'd1, 16'd2);
      send_cipher(16'hFFFF);
      send_cipher(16'd0);
      apply_settings(16'hFFFF, 16'd65521);
      send_cipher(16'hFFFF);
      send_cipher(16'h8001);
      // drain mid-stream under the same settings
      wait_drained();
      send_cipher(16'h7FFE);
   endtask

   task automatic test_random_settings();
      int unsigned phase;
      int unsigned k;
      logic [VW-1:0] exponent;
      logic [VW-1:0] modulus;
      logic [VW-1:0] cipher;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase % 4 == 3)
            exponent = VW'($urandom_range(256, 65535));
         else
            exponent = VW'($urandom_range(0, 255));
         if ($urandom_range(0, 3) == 0)
            modulus = VW'($urandom_range(2, 255));
         else
            modulus = VW'($urandom_range(256, 65535));
         apply_settings(exponent, modulus);
         gapless_left = $urandom_range(0, 30);
         for (k = 0; k < PHASE_REQUESTS; k++) begin
            if ($urandom_range(0, 9) < 7)
               cipher = VW'($urandom_range(0, modulus - 1));
            else
               cipher = VW'($urandom);
            send_cipher(cipher);
            if ($urandom_range(0, 63) == 0)
               wait_drained();
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_special_cases();
      test_extreme_settings();
      test_random_settings();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_plain.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_plain.size()));
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/rme_pkg.sv
rtl/core/rme_modmul.sv
rtl/core/rsa_modexp_decrypt.sv
tb/testbench.sv
